// File: rtl/csfw_pkg.sv
// ----------------------------------------------------------------------------
// csfw_pkg: shared types and constants of the counting semaphore
// Request and status codes, the decoded request carried between front and
// back, and the monitor view of the semaphore state.
// ----------------------------------------------------------------------------
package csfw_pkg;

    // field widths
    localparam int KIND_W   = 2;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 8;
    localparam int CNT_W    = 9;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 16;

    // parameter defaults
    localparam int WAIT_DEPTH_DEF     = 16;
    localparam int THREAD_ID_BITS_DEF = 8;

    // depth of the decoupling queue between front and back
    localparam int QDEPTH = 2;

    // request kinds on the wire
    localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANT = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SLEEP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT   = 3'd4;

    // count limits
    localparam logic signed [CNT_W-1:0] CNT_MAX = 9'sd255;
    localparam logic signed [CNT_W-1:0] CNT_ONE = 9'sd1;

    // decoded request class
    typedef enum logic [1:0] {
        OP_DOWN = 2'd0,
        OP_TRY  = 2'd1,
        OP_UP   = 2'd2,
        OP_BAD  = 2'd3
    } op_kind_t;

    // request as it travels from front to back
    typedef struct packed {
        op_kind_t          op;
        logic [ID_W-1:0]   id;
    } req_t;

    // semaphore state seen from the top level
    typedef struct packed {
        logic signed [CNT_W-1:0] count;
        logic [CNT_W-1:0]        fill;
    } sem_mon_t;

    // map a wire kind onto a request class
    function automatic op_kind_t classify(input logic [KIND_W-1:0] kind);
        op_kind_t op;
        unique case (kind)
            KIND_DOWN: op = OP_DOWN;
            KIND_TRY:  op = OP_TRY;
            KIND_UP:   op = OP_UP;
            default:   op = OP_BAD;
        endcase
        return op;
    endfunction

endpackage

// File: rtl/csfw_front.sv
// ----------------------------------------------------------------------------
// csfw_front: request intake
// Accepts requests from the input stream, classifies the kind and holds the
// decoded request in a register until the queue takes it.
// ----------------------------------------------------------------------------
module csfw_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [csfw_pkg::KIND_W-1:0]   s_kind,
    input  logic [csfw_pkg::ID_W-1:0]     s_id,
    output logic                          q_valid,
    input  logic                          q_ready,
    output csfw_pkg::req_t                q_req
);

    logic           valid_reg;
    logic           valid_next;
    csfw_pkg::req_t req_reg;

    // take a new request when the holding register is free or draining
    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_req   = req_reg;

    // occupancy of the holding register
    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // decoded payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.op <= csfw_pkg::classify(s_kind);
            req_reg.id <= s_id;
        end
    end

endmodule

// File: rtl/csfw_queue.sv
// ----------------------------------------------------------------------------
// csfw_queue: request queue between front and back
// A short FIFO of decoded requests so that intake and execution stall
// independently.
// ----------------------------------------------------------------------------
module csfw_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  csfw_pkg::req_t  in_req,
    output logic            out_valid,
    input  logic            out_ready,
    output csfw_pkg::req_t  out_req
);

    localparam int PTR_W = (csfw_pkg::QDEPTH > 1) ? $clog2(csfw_pkg::QDEPTH) : 1;
    localparam int OCC_W = $clog2(csfw_pkg::QDEPTH + 1);

    csfw_pkg::req_t   slot_reg [csfw_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             push;
    logic             pop;

    assign in_ready  = occ_reg != OCC_W'(csfw_pkg::QDEPTH);
    assign out_valid = occ_reg != '0;
    assign out_req   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer wrap
    function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(csfw_pkg::QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = push ? step(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? step(rd_ptr_reg) : rd_ptr_reg;
        occ_next    = occ_reg;
        if (push && !pop) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (pop && !push) begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// File: rtl/csfw_back.sv
// ----------------------------------------------------------------------------
// csfw_back: semaphore execution
// Holds the unit count and the waiter FIFO, executes one request per cycle
// while the output stream does not stall, and registers the result for it.
// ----------------------------------------------------------------------------
module csfw_back #(
    parameter int WAIT_DEPTH     = csfw_pkg::WAIT_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csfw_pkg::THREAD_ID_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [csfw_pkg::CFG_W-1:0]      cfg_value,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  csfw_pkg::req_t                  q_req,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [csfw_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_wake_valid,
    output logic [csfw_pkg::ID_W-1:0]       m_wake_thread,
    output csfw_pkg::sem_mon_t              mon
);

    localparam int PTR_W  = $clog2(WAIT_DEPTH);
    localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
    localparam int KEEP_W = (THREAD_ID_BITS < csfw_pkg::ID_W) ? THREAD_ID_BITS
                                                                : csfw_pkg::ID_W;

    logic [KEEP_W-1:0]                  waiter_mem [WAIT_DEPTH];
    logic signed [csfw_pkg::CNT_W-1:0]  count_reg;
    logic signed [csfw_pkg::CNT_W-1:0]  count_next;
    logic [PTR_W-1:0]                   head_reg;
    logic [PTR_W-1:0]                   head_next;
    logic [PTR_W-1:0]                   tail_reg;
    logic [PTR_W-1:0]                   tail_next;
    logic [FILL_W-1:0]                  fill_reg;
    logic [FILL_W-1:0]                  fill_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [csfw_pkg::STATUS_W-1:0]      status_reg;
    logic                               wake_valid_reg;
    logic [csfw_pkg::ID_W-1:0]          wake_thread_reg;
    logic [csfw_pkg::STATUS_W-1:0]      status_comb;
    logic                               take;
    logic                               do_push;
    logic                               do_pop;
    logic                               has_unit;
    logic                               full;

    // execute when the output register is free or being drained
    assign q_ready  = !out_valid_reg || m_ready;
    assign take     = q_valid && q_ready;
    assign has_unit = count_reg > 0;
    assign full     = fill_reg == FILL_W'(WAIT_DEPTH);

    assign m_valid       = out_valid_reg;
    assign m_status      = status_reg;
    assign m_wake_valid  = wake_valid_reg;
    assign m_wake_thread = wake_thread_reg;
    assign mon.count     = count_reg;
    assign mon.fill      = csfw_pkg::CNT_W'(fill_reg);

    // ring pointer wrap
    function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WAIT_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // request execution
    always_comb begin
        count_next  = count_reg;
        status_comb = csfw_pkg::ST_GRANT;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        unique case (q_req.op)
            csfw_pkg::OP_DOWN: begin
                if (has_unit) begin
                    count_next = count_reg - csfw_pkg::CNT_ONE;
                end else if (full) begin
                    status_comb = csfw_pkg::ST_FULL;
                end else begin
                    count_next  = count_reg - csfw_pkg::CNT_ONE;
                    do_push     = 1'b1;
                    status_comb = csfw_pkg::ST_SLEEP;
                end
            end
            csfw_pkg::OP_TRY: begin
                if (has_unit) begin
                    count_next = count_reg - csfw_pkg::CNT_ONE;
                end else begin
                    status_comb = csfw_pkg::ST_FAIL;
                end
            end
            csfw_pkg::OP_UP: begin
                if (count_reg >= csfw_pkg::CNT_MAX) begin
                    status_comb = csfw_pkg::ST_SAT;
                end else begin
                    count_next = count_reg + csfw_pkg::CNT_ONE;
                    do_pop     = (count_reg < 0) && (fill_reg != '0);
                end
            end
            default: begin
                status_comb = csfw_pkg::ST_FAIL;
            end
        endcase
    end

    // queue pointers and fill
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (take && do_push) begin
            tail_next = step(tail_reg);
            fill_next = fill_reg + FILL_W'(1);
        end
        if (take && do_pop) begin
            head_next = step(head_reg);
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    // output register occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state, reload on a configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= csfw_pkg::CNT_ONE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                count_reg <= $signed({1'b0, cfg_value});
                head_reg  <= '0;
                tail_reg  <= '0;
                fill_reg  <= '0;
            end else if (take) begin
                count_reg <= count_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                fill_reg  <= fill_next;
            end
        end
    end

    // waiter memory and result payload
    always_ff @(posedge aclk) begin
        if (take && do_push) begin
            waiter_mem[tail_reg] <= q_req.id[KEEP_W-1:0];
        end
        if (take) begin
            status_reg      <= status_comb;
            wake_valid_reg  <= do_pop;
            wake_thread_reg <= do_pop ? csfw_pkg::ID_W'(waiter_mem[head_reg]) : '0;
        end
    end

endmodule

// File: rtl/counting_semaphore_fifo_wait_unit.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_wait_unit: counting semaphore with FIFO wait queue
// Path: the intake register captures an accepted request, the request queue
// stores it and the result register then captures its result and raises
// m_axis_tvalid. Throughput: one request per cycle while the result stream
// is not stalled; the back stage updates count and waiter FIFO together.
// Reset is synchronous, active low: count 1, empty wait queue; a
// configuration write reloads the count and empties it.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_wait_unit #(
    parameter int WAIT_DEPTH     = csfw_pkg::WAIT_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csfw_pkg::THREAD_ID_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: initial_count
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csfw_pkg::CFG_W-1:0]          cfg_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [csfw_pkg::TDATA_IN_W-1:0]     s_axis_tdata,   // [7:0] thread_id
    input  logic [csfw_pkg::KIND_W-1:0]         s_axis_tuser,   // [1:0] kind
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [csfw_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,   // [2:0] status,
                                                                // [10:3] wake_thread
    output logic                                m_axis_tuser    // [0] wake_valid
);

    localparam int PAD_W = csfw_pkg::TDATA_OUT_W - csfw_pkg::STATUS_W - csfw_pkg::ID_W;

    logic                           fq_valid;
    logic                           fq_ready;
    csfw_pkg::req_t                 fq_req;
    logic                           qb_valid;
    logic                           qb_ready;
    csfw_pkg::req_t                 qb_req;
    logic [csfw_pkg::STATUS_W-1:0]  res_status;
    logic [csfw_pkg::ID_W-1:0]      res_thread;
    csfw_pkg::sem_mon_t             mon;

    assign cfg_ready = 1'b1;

    // intake and classification
    csfw_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_kind  (s_axis_tuser),
        .s_id    (s_axis_tdata[csfw_pkg::ID_W-1:0]),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_req   (fq_req)
    );

    // decoupling queue
    csfw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_req    (fq_req),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_req   (qb_req)
    );

    // semaphore execution
    csfw_back #(
        .WAIT_DEPTH     (WAIT_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_value     (cfg_data),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_req         (qb_req),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .m_status      (res_status),
        .m_wake_valid  (m_axis_tuser),
        .m_wake_thread (res_thread),
        .mon           (mon)
    );

    // result packing
    assign m_axis_tdata = {{PAD_W{1'b0}}, res_thread, res_status};

    // a negative count always equals the number of queued waiters
    assert property (@(posedge aclk) disable iff (!aresetn)
        mon.fill == ((mon.count < 0) ? -mon.count : '0))
    else $error("count and waiter fill disagree");

    // the waiter queue never holds more than its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        mon.fill <= csfw_pkg::CNT_W'(WAIT_DEPTH))
    else $error("waiter fill beyond depth");

    // a woken thread only comes with a granted up
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[2:0] == csfw_pkg::ST_GRANT))
    else $error("wake reported with a non-grant status");

    // a thread id is only reported with a wake
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (res_thread == '0))
    else $error("thread id without wake");

endmodule

// File: dv/semaphore_checker.sv
// ----------------------------------------------------------------------------
// semaphore_checker: result predictor and comparator for the semaphore unit
// Watches the configuration, request and result channels. Each accepted
// request is run through a local model of the count and the waiter FIFO.
// Each accepted result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module semaphore_checker
    import csfw_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [TDATA_IN_W-1:0]   s_axis_tdata,   // [7:0] thread_id
    input  logic [KIND_W-1:0]       s_axis_tuser,   // [1:0] kind
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [TDATA_OUT_W-1:0]  m_axis_tdata,   // [2:0] status, [10:3] wake_thread
    input  logic                    m_axis_tuser,   // [0] wake_valid
    output int                      failures,
    output int                      pending,
    output int                      results_seen,
    output int                      wakes_seen,
    output int                      full_seen,
    output int                      sat_seen
);

    localparam int PTR_W = $clog2(WAIT_DEPTH_DEF);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                wake_valid;
        logic [ID_W-1:0]     wake_thread;
    } sem_result_t;

    // local copy of the semaphore state
    logic [CFG_W-1:0]        start_units;
    logic signed [CNT_W-1:0] units;
    logic [ID_W-1:0]         sleepers [WAIT_DEPTH_DEF];
    logic [PTR_W-1:0]        head;
    logic [PTR_W-1:0]        tail;
    logic [PTR_W:0]          fill;

    sem_result_t awaited_results [$];

    // reload the count and empty the wait queue
    function automatic void reload_semaphore();
        units = $signed({1'b0, start_units});
        head  = '0;
        tail  = '0;
        fill  = '0;
    endfunction

    // apply one request to the local state and return its result
    function automatic sem_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                  input logic [ID_W-1:0] id);
        sem_result_t r;
        r        = '0;
        r.status = ST_GRANT;
        case (op_kind_t'(kind))
            OP_DOWN: begin
                if (units > 0) begin
                    units = units - CNT_ONE;
                end else if (fill >= WAIT_DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    // pointers wrap on their own, the depth is a power of two
                    sleepers[tail] = id;
                    tail  = tail + 1'b1;
                    fill  = fill + 1'b1;
                    units = units - CNT_ONE;
                    r.status = ST_SLEEP;
                end
            end
            OP_TRY: begin
                if (units > 0)
                    units = units - CNT_ONE;
                else
                    r.status = ST_FAIL;
            end
            OP_UP: begin
                if (units >= CNT_MAX) begin
                    r.status = ST_SAT;
                end else begin
                    units = units + CNT_ONE;
                    if (units <= 0 && fill > 0) begin
                        r.wake_valid  = 1'b1;
                        r.wake_thread = sleepers[head];
                        head = head + 1'b1;
                        fill = fill - 1'b1;
                    end
                end
            end
            default: r.status = ST_FAIL;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        failures++;
    endtask

    // track config writes, predict on request, compare on result
    always @(posedge aclk) begin
        sem_result_t want;
        sem_result_t got;
        if (!aresetn) begin
            start_units = 8'd1;
            reload_semaphore();
            awaited_results.delete();
            failures     = 0;
            results_seen = 0;
            wakes_seen   = 0;
            full_seen    = 0;
            sat_seen     = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                start_units = cfg_data;
                reload_semaphore();
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status      = m_axis_tdata[STATUS_W-1:0];
                got.wake_thread = m_axis_tdata[STATUS_W +: ID_W];
                got.wake_valid  = m_axis_tuser;
                results_seen++;
                if (got.wake_valid)
                    wakes_seen++;
                if (got.status == ST_FULL)
                    full_seen++;
                if (got.status == ST_SAT)
                    sat_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result status %0d with no request outstanding",
                                              got.status));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.wake_valid != want.wake_valid)
                        report_mismatch($sformatf("wake_valid %0d, expected %0d",
                                                  got.wake_valid, want.wake_valid));
                    if (got.wake_thread != want.wake_thread)
                        report_mismatch($sformatf("wake_thread 0x%02h, expected 0x%02h",
                                                  got.wake_thread, want.wake_thread));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(apply_request(s_axis_tuser,
                                                        s_axis_tdata[ID_W-1:0]));
        end
        pending = awaited_results.size();
    end

endmodule

// File: dv/tb_counting_semaphore_fifo_wait_unit.sv
// ----------------------------------------------------------------------------
// tb_counting_semaphore_fifo_wait_unit: testbench of the semaphore unit
// Drives directed and random down, try-down, up and unused-kind requests under several
// initial counts, with random stalls on both streams; the checker predicts
// every result and compares it with what the unit returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo_wait_unit;
    import csfw_pkg::*;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data      = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TDATA_IN_W-1:0]   s_axis_tdata  = '0;   // [7:0] thread_id
    logic [KIND_W-1:0]       s_axis_tuser  = '0;   // [1:0] kind
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_axis_tdata;         // [2:0] status, [10:3] wake_thread
    logic                    m_axis_tuser;         // [0] wake_valid

    int failures;
    int pending;
    int results_seen;
    int wakes_seen;
    int full_seen;
    int sat_seen;

    bit idle_on         = 1'b1;
    int stall_left      = 0;
    int requests_sent   = 0;
    int settings_loaded = 1;

    int                 phase;
    int                 n;
    int                 r;
    int                 down_lim;
    int                 try_lim;
    int                 up_lim;
    logic [KIND_W-1:0]  pick;
    logic [CFG_W-1:0]   start_value;

    counting_semaphore_fifo_wait_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    semaphore_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .pending       (pending),
        .results_seen  (results_seen),
        .wakes_seen    (wakes_seen),
        .full_seen     (full_seen),
        .sat_seen      (sat_seen)
    );

    // 4 ns clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side back-pressure in random bursts
    always @(negedge aclk) begin
        if (idle_on && stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one request, with an optional idle burst ahead of it
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= id;
        s_axis_tuser  <= kind;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
    endtask

    // load initial_count once every outstanding result has come back
    task automatic write_initial_count(input logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset count of one, grant, try, refusal of the unused kind
        send_request(KIND_UP,   8'h5A);
        send_request(KIND_TRY,  8'h00);
        send_request(KIND_DOWN, 8'h11);
        send_request(KIND_TRY,  8'hFF);
        send_request(OP_BAD,    8'hA5);

        // directed: up at the maximum count
        write_initial_count(8'd255);
        send_request(KIND_UP, 8'h3C);

        // directed: zero start, fill the wait queue, overflow it, wake in order
        write_initial_count(8'd0);
        for (n = 0; n < WAIT_DEPTH_DEF; n++)
            send_request(KIND_DOWN, (n == 0) ? 8'h00 :
                                    (n == WAIT_DEPTH_DEF - 1) ? 8'hFF : 8'($urandom));
        send_request(KIND_DOWN, 8'h77);
        send_request(KIND_UP, 8'h01);
        send_request(KIND_UP, 8'h02);

        // random phases, each with its own start count and request mix
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       start_value = 8'd2;
                1:       start_value = 8'd255;
                2:       start_value = 8'($urandom_range(1, 20));
                3:       start_value = 8'd0;
                4:       start_value = 8'd255;
                6:       start_value = 8'd1;
                default: start_value = 8'($urandom);
            endcase
            write_initial_count(start_value);
            // mostly downs, mostly ups, or an even mix
            case (phase % 3)
                0: begin
                    down_lim = 55; try_lim = 65; up_lim = 96;
                end
                1: begin
                    down_lim = 25; try_lim = 35; up_lim = 96;
                end
                default: begin
                    down_lim = 40; try_lim = 55; up_lim = 95;
                end
            endcase
            for (n = 0; n < 225; n++) begin
                // a calm stretch in each phase, none at all in the last one
                idle_on = (phase != 7) && !(n >= 150 && n < 190);
                r = $urandom_range(0, 99);
                if (r < down_lim)
                    pick = KIND_DOWN;
                else if (r < try_lim)
                    pick = KIND_TRY;
                else if (r < up_lim)
                    pick = KIND_UP;
                else
                    pick = OP_BAD;
                send_request(pick, 8'($urandom));
            end
        end

        // drain
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("ran %0d requests under %0d count settings, %0d results checked",
                 requests_sent, settings_loaded, results_seen);
        $display("wakeups %0d, full-queue refusals %0d, saturated ups %0d, mismatches %0d",
                 wakes_seen, full_seen, sat_seen, failures);
        if (failures == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
